// ----- hdl/psclim_pkg.sv -----
// Package for the per-source connection limiter: item types, operation codes,
// table entry layout and default sizes. No dependencies.

package psclim_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 16;

  localparam int DEF_BUCKETS = 256;
  localparam int DEF_WAYS    = 4;

  localparam logic [CNT_W-1:0] MAX_PER_SOURCE_RST = 16'd64;
  localparam logic [CNT_W-1:0] CNT_SAT            = 16'hFFFF;

  localparam logic [1:0] FUNC_CHECK = 2'd0;
  localparam logic [1:0] FUNC_OPEN  = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] source_addr;
  } in_item_t;

  typedef struct packed {
    logic             allowed;
    logic [CNT_W-1:0] conn_count;
    logic             was_found;
    logic             dropped;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

endpackage

// ----- hdl/psclim_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.

module psclim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/per_source_connection_limiter_unit.sv -----
// Top level of the per-source connection limiter: sequencer, hash unit, way
// scanner and result register around one table RAM.
// Depends on psclim_pkg and psclim_ram.
//
//  Channel  Ports                              Direction  Carries
//  input    in_valid, in_stall, in_item        in         func, source_addr
//  result   out_valid, out_stall, out_item     out        allowed, conn_count,
//                                                         was_found, dropped
//  config   cfg_valid, cfg_ready, cfg_data     in         max_per_source
//
// The taken item passes through the SCAN state once per way, then DRAIN, then
// UPDATE, which loads the result and writes the table; the block then returns
// to IDLE for the next item, so items do not overlap. When BUCKETS is not a
// power of two, a HASH state first computes the bucket by reciprocal
// multiplication on one shared multiplier. The way scan reads one table entry
// per cycle through the single RAM read port. After reset the table is swept
// once, clearing every entry, before the first item is taken; configuration
// writes are accepted at any time. A result waiting in the output register
// holds off the table update and the return to IDLE, and with it the next item.

module per_source_connection_limiter_unit #(
  parameter int BUCKETS = psclim_pkg::DEF_BUCKETS,
  parameter int WAYS    = psclim_pkg::DEF_WAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psclim_pkg::in_item_t          in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psclim_pkg::out_item_t         out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psclim_pkg::CNT_W-1:0]  cfg_data
);

  import psclim_pkg::*;

  localparam int SLOTS    = BUCKETS * WAYS;
  localparam int SLOT_W   = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int BKT_W    = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam bit BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  // Reciprocal of BUCKETS, rounded up, scaled so that the quotient of any
  // 32-bit address comes out exact after the shift.
  localparam int               PROD_W  = 2 * ADDR_W + 1;
  localparam int               RCP_L   = $clog2(BUCKETS);
  localparam logic [63:0]      RCP_NUM = 64'd1 << (ADDR_W + RCP_L);
  localparam logic [63:0]      RCP_M64 = (RCP_NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [ADDR_W:0]  RCP_M   = RCP_M64[ADDR_W:0];

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  state_t            state_r;
  logic [SLOT_W-1:0] clr_idx_r;
  logic [CNT_W-1:0]  max_r;
  logic [1:0]        func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BKT_W-1:0]  bucket_r;
  logic              hash_ph_r;
  logic [ADDR_W-1:0] quot_r;
  logic [WAY_W-1:0]  way_r;
  logic [WAY_W-1:0]  chk_way_r;
  logic              chk_r;
  logic              found_r;
  logic [WAY_W-1:0]  hit_way_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic              free_r;
  logic [WAY_W-1:0]  free_way_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  // RAM ports
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [SLOT_BITS-1:0] ram_wdata;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [SLOT_BITS-1:0] ram_rdata;

  slot_t             rd_ent;
  logic              cmp_hit;
  logic              cmp_free;
  logic [ADDR_W-1:0] mul_a;
  logic [ADDR_W:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              out_free;
  logic              upd_we;
  logic [WAY_W-1:0]  upd_way;
  slot_t             upd_ent;
  out_item_t         res_nxt;
  logic              present;
  logic [CNT_W-1:0]  cnt_after;

  psclim_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Bucket remainder in two passes through the multiplier: the first pass
  // multiplies by the reciprocal to get the quotient, the second multiplies
  // the quotient back by BUCKETS so it can be taken off the address.
  always_comb begin
    if (!hash_ph_r) begin
      mul_a = addr_r;
      mul_b = RCP_M;
    end else begin
      mul_a = quot_r;
      mul_b = (ADDR_W + 1)'(BUCKETS);
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Shared compare unit: checks the entry that the RAM returned this cycle.
  always_comb begin
    rd_ent   = slot_t'(ram_rdata);
    cmp_hit  = chk_r && rd_ent.valid && (rd_ent.addr == addr_r);
    cmp_free = chk_r && !rd_ent.valid && !free_r;
  end

  // Table update and result for the finished scan.
  always_comb begin
    upd_we        = 1'b0;
    upd_way       = hit_way_r;
    upd_ent       = '0;
    upd_ent.addr  = addr_r;
    present       = found_r;
    cnt_after     = hit_cnt_r;
    res_nxt       = '0;
    res_nxt.was_found = found_r;
    case (func_r)
      FUNC_OPEN: begin
        if (found_r) begin
          upd_we    = 1'b1;
          cnt_after = (hit_cnt_r == CNT_SAT) ? hit_cnt_r : hit_cnt_r + 1'b1;
        end else if (free_r) begin
          upd_we    = 1'b1;
          upd_way   = free_way_r;
          present   = 1'b1;
          cnt_after = CNT_W'(1);
        end else begin
          res_nxt.dropped = 1'b1;
        end
        upd_ent.valid = 1'b1;
        upd_ent.count = cnt_after;
      end
      FUNC_CLOSE: begin
        if (found_r) begin
          upd_we = 1'b1;
          if (hit_cnt_r <= CNT_W'(1)) begin
            present   = 1'b0;
            cnt_after = '0;
          end else begin
            cnt_after = hit_cnt_r - 1'b1;
          end
          upd_ent.valid = present;
          upd_ent.count = cnt_after;
        end
      end
      default: begin
        // Check, and the unused code, leave the table alone.
      end
    endcase
    res_nxt.conn_count = present ? cnt_after : '0;
    res_nxt.allowed    = !present || (cnt_after < max_r);
  end

  always_comb begin
    ram_raddr = SLOT_W'(32'(bucket_r) * WAYS + 32'(way_r));
    ram_we    = 1'b0;
    ram_waddr = clr_idx_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == S_UPDATE && out_free) begin
      ram_we    = upd_we;
      ram_waddr = SLOT_W'(32'(bucket_r) * WAYS + 32'(upd_way));
      ram_wdata = upd_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      max_r       <= MAX_PER_SOURCE_RST;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != S_UPDATE) begin
        out_valid_r <= 1'b0;
      end

      if (cmp_hit) begin
        found_r   <= 1'b1;
        hit_way_r <= chk_way_r;
        hit_cnt_r <= rd_ent.count;
      end
      if (cmp_free) begin
        free_r     <= 1'b1;
        free_way_r <= chk_way_r;
      end

      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r    <= in_item.func;
            addr_r    <= in_item.source_addr;
            found_r   <= 1'b0;
            free_r    <= 1'b0;
            way_r     <= '0;
            hash_ph_r <= 1'b0;
            if (BKT_POW2) begin
              bucket_r <= BKT_W'(in_item.source_addr & ADDR_W'(BUCKETS - 1));
              state_r  <= S_SCAN;
            end else begin
              state_r  <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (!hash_ph_r) begin
            quot_r    <= ADDR_W'(mul_p >> (ADDR_W + RCP_L));
            hash_ph_r <= 1'b1;
          end else begin
            bucket_r <= BKT_W'(addr_r - mul_p[ADDR_W-1:0]);
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_r     <= 1'b1;
          chk_way_r <= way_r;
          way_r     <= way_r + 1'b1;
          if (way_r == WAY_W'(WAYS - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          chk_r   <= 1'b0;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_item_r  <= res_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block still ready in the cycle after taking an item");

  a_drop_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.dropped && out_item_r.was_found))
    else $error("dropped open reported for an address that was present");

  a_refuse_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.allowed |-> out_item_r.conn_count != '0)
    else $error("refused item with zero connection count");

  a_load_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPDATE))
    else $error("result loaded outside the update step");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for per_source_connection_limiter_unit: directed and random
// check, open and close requests under several per-source limits, checked against a shadow table.
// Depends on psclim_pkg and the limiter RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psclim_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int SLOTS            = DEF_BUCKETS * DEF_WAYS;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_PER_PHASE = 225;
  localparam int MAX_REPORTS      = 40;
  localparam int HOT_BUCKETS      = 8;
  localparam int ADDRS_PER_BUCKET = 6;
  localparam int HOT_ADDRS        = HOT_BUCKETS * ADDRS_PER_BUCKET;

  // Shadow copy of the connection table; every accepted request is replayed on it
  // and the verdict it yields waits here until the block returns its own.
  class conn_table_tracker;
    bit                used [SLOTS];
    logic [ADDR_W-1:0] src [SLOTS];
    logic [CNT_W-1:0]  cnt [SLOTS];
    logic [CNT_W-1:0]  limit;
    out_item_t         verdicts_due [$];
    int                fails;

    function new();
      limit = MAX_PER_SOURCE_RST;
      fails = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    task report(string msg);
      if (fails < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
      fails++;
    endtask

    function void note_request(in_item_t req);
      int base;
      int way;
      int w;
      bit present;
      out_item_t res;
      base = int'(req.source_addr % DEF_BUCKETS) * DEF_WAYS;
      way = DEF_WAYS;
      for (w = DEF_WAYS - 1; w >= 0; w--)
        if (used[base + w] && src[base + w] == req.source_addr) way = w;
      present = (way != DEF_WAYS);
      res = '0;
      res.was_found = present;
      if (req.func == FUNC_OPEN) begin
        if (!present) begin
          // A new address takes the lowest free way of its bucket.
          for (w = DEF_WAYS - 1; w >= 0; w--)
            if (!used[base + w]) way = w;
          if (way != DEF_WAYS) begin
            used[base + way] = 1'b1;
            src[base + way]  = req.source_addr;
            cnt[base + way]  = '0;
            present = 1'b1;
          end else begin
            res.dropped = 1'b1;
          end
        end
        if (present && cnt[base + way] != CNT_SAT)
          cnt[base + way] = cnt[base + way] + 1'b1;
      end else if (req.func == FUNC_CLOSE && present) begin
        if (cnt[base + way] <= 1) begin
          used[base + way] = 1'b0;
          cnt[base + way]  = '0;
          present = 1'b0;
        end else begin
          cnt[base + way] = cnt[base + way] - 1'b1;
        end
      end
      res.conn_count = present ? cnt[base + way] : '0;
      res.allowed    = !present || (res.conn_count < limit);
      verdicts_due.push_back(res);
    endfunction

    task check_verdict(out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result with no request outstanding: allowed=%0b count=%0d",
                         got.allowed, got.conn_count));
      end else begin
        want = verdicts_due.pop_front();
        if (got.allowed !== want.allowed)
          report($sformatf("allowed %0b, want %0b", got.allowed, want.allowed));
        if (got.conn_count !== want.conn_count)
          report($sformatf("conn_count %0d, want %0d", got.conn_count, want.conn_count));
        if (got.was_found !== want.was_found)
          report($sformatf("was_found %0b, want %0b", got.was_found, want.was_found));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped %0b, want %0b", got.dropped, want.dropped));
      end
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  bit                steady = 1'b0;
  logic [ADDR_W-1:0] hot_addr [HOT_ADDRS];
  conn_table_tracker shadow;

  per_source_connection_limiter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: check what was taken at this edge, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_verdict(out_item);
    out_stall <= !steady && ($urandom_range(99) < 27);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("per_source_connection_limiter_unit verification failed");
    $finish;
  end

  function automatic in_item_t make_request(logic [1:0] func, logic [ADDR_W-1:0] addr);
    in_item_t req;
    req.func        = func;
    req.source_addr = addr;
    return req;
  endfunction

  // Mostly opens and closes on a small set of crowded buckets, so that counts
  // climb past the limit and buckets fill; now and then a stray address.
  function automatic in_item_t random_request();
    int pick;
    logic [1:0] func;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    if (pick < 40)      func = FUNC_OPEN;
    else if (pick < 75) func = FUNC_CLOSE;
    else if (pick < 93) func = FUNC_CHECK;
    else                func = FUNC_SPARE;
    if ($urandom_range(99) < 85) addr = hot_addr[$urandom_range(HOT_ADDRS - 1)];
    else                         addr = $urandom();
    return make_request(func, addr);
  endfunction

  task automatic send_request(in_item_t req);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 27) gap++;
      if ($urandom_range(99) < 4) gap += $urandom_range(12);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    shadow.note_request(req);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.set_limit(value);
  endtask

  task automatic random_phase(logic [CNT_W-1:0] limit_value, bit no_idle);
    write_limit(limit_value);
    steady = no_idle;
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    settle();
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] crowded [HOT_BUCKETS];
    in_item_t   directed [$];
    shadow = new();
    crowded = '{8'h00, 8'h01, 8'h3C, 8'h7F, 8'h80, 8'hC3, 8'hFE, 8'hFF};
    foreach (hot_addr[i])
      hot_addr[i] = {24'($urandom_range(32'hFF_FFFF)), crowded[i / ADDRS_PER_BUCKET]};

    // Absent address, unknown close and the spare selector come first; then the
    // top bucket is filled until an open is dropped, and a freed way is reused.
    directed.push_back(make_request(FUNC_CHECK, 32'h0000_0000));
    directed.push_back(make_request(FUNC_CLOSE, 32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_SPARE, 32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_OPEN,  32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_OPEN,  32'h0000_00FF));
    directed.push_back(make_request(FUNC_OPEN,  32'h1234_56FF));
    directed.push_back(make_request(FUNC_OPEN,  32'hABCD_EFFF));
    directed.push_back(make_request(FUNC_OPEN,  32'h5555_55FF));
    directed.push_back(make_request(FUNC_CHECK, 32'h5555_55FF));
    directed.push_back(make_request(FUNC_OPEN,  32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_CHECK, 32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_CLOSE, 32'h0000_00FF));
    directed.push_back(make_request(FUNC_OPEN,  32'h5555_55FF));
    directed.push_back(make_request(FUNC_CLOSE, 32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_CLOSE, 32'hFFFF_FFFF));
    directed.push_back(make_request(FUNC_SPARE, 32'h1234_56FF));
    directed.push_back(make_request(FUNC_OPEN,  32'h0000_0000));
    directed.push_back(make_request(FUNC_OPEN,  32'h8000_0000));
    directed.push_back(make_request(FUNC_CHECK, 32'h0000_0000));
    directed.push_back(make_request(FUNC_CLOSE, 32'h8000_0000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);
    settle();

    random_phase(16'd1, 1'b0);
    random_phase(16'd0, 1'b0);
    random_phase(CNT_W'($urandom_range(2, 6)), 1'b1);
    random_phase(CNT_W'($urandom_range(7, 65534)), 1'b0);
    random_phase(16'd3, 1'b0);
    random_phase(CNT_SAT, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.fails == 0 && shadow.pending() == 0)
      $display("per_source_connection_limiter_unit verification clean");
    else
      $display("per_source_connection_limiter_unit verification failed");
    $finish;
  end

endmodule
